[rtl/core/mftp_pkg.sv]
// Shared types and constants of the MIDI file track event parser.
`timescale 1ns / 1ps

package mftp_pkg;

    // Special status and meta values.
    localparam logic [7:0] BYTE_SYSEX     = 8'hF0;
    localparam logic [7:0] BYTE_ESCAPE    = 8'hF7;
    localparam logic [7:0] BYTE_META      = 8'hFF;
    localparam logic [3:0] NIB_PROGRAM    = 4'hC;
    localparam logic [3:0] NIB_PRESSURE   = 4'hD;
    localparam logic [8:0] META_NONE      = 9'h1FF;
    localparam logic [8:0] META_END_TRACK = 9'h02F;

    // Error codes carried on a result.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_STATUS   = 2'd1;
    localparam logic [1:0] ERR_TRUNC    = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    // Result queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic [7:0]        msg_byte;
        logic              has_data;
        logic              first_of_event;
        logic              last_of_event;
        logic signed [8:0] meta_kind;
        logic [27:0]       delta_ticks;
        logic [31:0]       event_tick;
        logic              track_done;
        logic [1:0]        error_code;
        logic              final_for_input;
    } t_result;

    // Results produced by one accepted input item.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

[rtl/core/mftp_parser.sv]
// Track chunk decoder: parser state and the results of one input item.
`timescale 1ns / 1ps

module mftp_parser #(
    parameter int VLQ_MAX_BYTES = 4,
    parameter int TICK_BITS     = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte_value,
    input  logic            i_track_start,
    input  logic            i_chunk_end,
    output mftp_pkg::t_push o_push
);
    import mftp_pkg::*;

    localparam int CNT_W = (VLQ_MAX_BYTES > 1) ? $clog2(VLQ_MAX_BYTES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VLQ_MAX_BYTES - 1);
    localparam int EW = (TICK_BITS < 32) ? TICK_BITS : 32;

    localparam logic [2:0] PH_DELTA  = 3'd0;
    localparam logic [2:0] PH_STATUS = 3'd1;
    localparam logic [2:0] PH_MTYPE  = 3'd2;
    localparam logic [2:0] PH_LEN    = 3'd3;
    localparam logic [2:0] PH_BODY   = 3'd4;

    logic [2:0]           r_phase,  n_phase,  e_phase;
    logic [27:0]          r_acc,    n_acc,    e_acc;
    logic [CNT_W-1:0]     r_cnt,    n_cnt,    e_cnt;
    logic [7:0]           r_rs,     n_rs,     e_rs;
    logic [7:0]           r_status, n_status, e_status;
    logic [8:0]           r_meta,   n_meta,   e_meta;
    logic [27:0]          r_rem,    n_rem,    e_rem;
    logic [27:0]          r_delta,  n_delta,  e_delta;
    logic [TICK_BITS-1:0] r_tick,   n_tick,   e_tick;
    logic                 r_halted, n_halted, e_halted;
    logic                 r_fp,     n_fp,     e_fp;

    logic [27:0] acc_shift;
    logic        vlq_cont;
    logic        vlq_ovf;
    logic        end_track;
    logic [27:0] rem_dec;
    logic [31:0] tick32;
    logic        rs_short;
    logic        b_short;
    logic [1:0]  err;
    t_push       push;

    function automatic t_result mk_res(input logic [7:0] b, input logic has,
                                       input logic first, input logic last,
                                       input logic done, input logic [8:0] meta,
                                       input logic [27:0] delta,
                                       input logic [31:0] tick);
        t_result r;
        r.msg_byte        = b;
        r.has_data        = has;
        r.first_of_event  = first;
        r.last_of_event   = last;
        r.meta_kind       = meta;
        r.delta_ticks     = delta;
        r.event_tick      = tick;
        r.track_done      = done;
        r.error_code      = ERR_NONE;
        r.final_for_input = 1'b0;
        return r;
    endfunction

    always_comb begin
        // A track start clears the state before the byte is decoded.
        if (i_track_start) begin
            e_phase = PH_DELTA; e_acc = '0; e_cnt = '0; e_rs = '0; e_status = '0;
            e_meta = META_NONE; e_rem = '0; e_delta = '0; e_tick = '0;
            e_halted = 1'b0; e_fp = 1'b0;
        end else begin
            e_phase = r_phase; e_acc = r_acc; e_cnt = r_cnt; e_rs = r_rs;
            e_status = r_status; e_meta = r_meta; e_rem = r_rem; e_delta = r_delta;
            e_tick = r_tick; e_halted = r_halted; e_fp = r_fp;
        end

        n_phase = e_phase; n_acc = e_acc; n_cnt = e_cnt; n_rs = e_rs;
        n_status = e_status; n_meta = e_meta; n_rem = e_rem; n_delta = e_delta;
        n_tick = e_tick; n_halted = e_halted; n_fp = e_fp;

        acc_shift = {e_acc[20:0], i_byte_value[6:0]};
        vlq_cont  = i_byte_value[7];
        vlq_ovf   = vlq_cont && (e_cnt == CNT_LAST);
        end_track = (e_meta == META_END_TRACK);
        rem_dec   = e_rem - 28'd1;
        tick32    = 32'(e_tick[EW-1:0]);
        rs_short  = (e_rs[7:4] == NIB_PROGRAM) || (e_rs[7:4] == NIB_PRESSURE);
        b_short   = (i_byte_value[7:4] == NIB_PROGRAM) ||
                    (i_byte_value[7:4] == NIB_PRESSURE);
        err       = ERR_NONE;

        push.count = 2'd0;
        push.res0  = mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, META_NONE, 28'd0, 32'd0);
        push.res1  = push.res0;

        if (!e_halted) begin
            unique case (e_phase)
                PH_DELTA: begin
                    n_acc = acc_shift;
                    if (vlq_cont) begin
                        if (vlq_ovf) begin
                            err = ERR_OVERFLOW;
                        end else begin
                            n_cnt = e_cnt + CNT_W'(1);
                        end
                    end else begin
                        n_delta = acc_shift;
                        n_tick  = e_tick + TICK_BITS'(acc_shift);
                        n_acc   = '0;
                        n_cnt   = '0;
                        n_phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (!i_byte_value[7]) begin
                        // Data byte in status position: running status repeats.
                        if (e_rs == 8'h00) begin
                            err = ERR_STATUS;
                        end else begin
                            n_status   = e_rs;
                            n_meta     = META_NONE;
                            push.count = 2'd2;
                            push.res0  = mk_res(e_rs, 1'b1, 1'b1, 1'b0, 1'b0,
                                                META_NONE, e_delta, tick32);
                            push.res1  = mk_res(i_byte_value, 1'b1, 1'b0, rs_short,
                                                1'b0, META_NONE, e_delta, tick32);
                            if (rs_short) begin
                                n_phase = PH_DELTA;
                            end else begin
                                n_rem   = 28'd1;
                                n_fp    = 1'b0;
                                n_phase = PH_BODY;
                            end
                        end
                    end else if (i_byte_value < BYTE_SYSEX) begin
                        n_rs       = i_byte_value;
                        n_status   = i_byte_value;
                        n_meta     = META_NONE;
                        push.count = 2'd1;
                        push.res0  = mk_res(i_byte_value, 1'b1, 1'b1, 1'b0, 1'b0,
                                            META_NONE, e_delta, tick32);
                        n_rem      = b_short ? 28'd1 : 28'd2;
                        n_fp       = 1'b0;
                        n_phase    = PH_BODY;
                    end else if (i_byte_value == BYTE_SYSEX ||
                                 i_byte_value == BYTE_ESCAPE) begin
                        n_status = i_byte_value;
                        n_meta   = META_NONE;
                        n_acc    = '0;
                        n_cnt    = '0;
                        n_phase  = PH_LEN;
                    end else if (i_byte_value == BYTE_META) begin
                        n_status = i_byte_value;
                        n_phase  = PH_MTYPE;
                    end else begin
                        err = ERR_STATUS;
                    end
                end
                PH_MTYPE: begin
                    n_meta  = {1'b0, i_byte_value};
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_acc = acc_shift;
                    if (vlq_cont) begin
                        if (vlq_ovf) begin
                            err = ERR_OVERFLOW;
                        end else begin
                            n_cnt = e_cnt + CNT_W'(1);
                        end
                    end else begin
                        n_acc = '0;
                        n_cnt = '0;
                        if (acc_shift == 28'd0) begin
                            // Empty sysex or meta event gives one marker.
                            push.count = 2'd1;
                            push.res0  = mk_res(8'h00, 1'b0, 1'b1, 1'b1, end_track,
                                                e_meta, e_delta, tick32);
                            n_phase    = PH_DELTA;
                            n_halted   = end_track;
                        end else begin
                            if (e_status == BYTE_SYSEX) begin
                                push.count = 2'd1;
                                push.res0  = mk_res(BYTE_SYSEX, 1'b1, 1'b1, 1'b0, 1'b0,
                                                    e_meta, e_delta, tick32);
                                n_fp       = 1'b0;
                            end else begin
                                n_fp = 1'b1;
                            end
                            n_rem   = acc_shift;
                            n_phase = PH_BODY;
                        end
                    end
                end
                default: begin
                    // Event body; unused phase codes behave the same way.
                    n_rem      = rem_dec;
                    n_fp       = 1'b0;
                    push.count = 2'd1;
                    if (rem_dec == 28'd0) begin
                        push.res0 = mk_res(i_byte_value, 1'b1, e_fp, 1'b1, end_track,
                                           e_meta, e_delta, tick32);
                        n_phase   = PH_DELTA;
                        n_halted  = end_track;
                    end else begin
                        push.res0 = mk_res(i_byte_value, 1'b1, e_fp, 1'b0, 1'b0,
                                           e_meta, e_delta, tick32);
                    end
                end
            endcase

            if (err != ERR_NONE) begin
                n_halted = 1'b1;
            end else if (i_chunk_end) begin
                if (!n_halted && !(n_phase == PH_DELTA && n_cnt == '0)) begin
                    err = ERR_TRUNC;
                end
                n_halted = 1'b1;
            end

            if (err != ERR_NONE && push.count == 2'd0) begin
                push.count = 2'd1;
            end

            if (push.count == 2'd2) begin
                push.res1.error_code      = err;
                push.res1.final_for_input = 1'b1;
            end else begin
                push.res0.error_code      = err;
                push.res0.final_for_input = 1'b1;
            end
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_DELTA;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_rs     <= '0;
            r_status <= '0;
            r_meta   <= META_NONE;
            r_rem    <= '0;
            r_delta  <= '0;
            r_tick   <= '0;
            r_halted <= 1'b0;
            r_fp     <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_rs     <= n_rs;
            r_status <= n_status;
            r_meta   <= n_meta;
            r_rem    <= n_rem;
            r_delta  <= n_delta;
            r_tick   <= n_tick;
            r_halted <= n_halted;
            r_fp     <= n_fp;
        end
    end

endmodule

[rtl/core/mftp_out_queue.sv]
// Result queue: takes up to two results per cycle and hands out one per cycle.
`timescale 1ns / 1ps

module mftp_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_en,
    input  mftp_pkg::t_push   i_push,
    input  logic              i_pop,
    output logic              o_room,
    output logic              o_valid,
    output mftp_pkg::t_result o_head
);
    import mftp_pkg::*;

    t_result           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_head, n_head;
    logic [QPTR_W-1:0] r_tail, n_tail;
    logic [QCNT_W-1:0] r_count, n_count;
    logic [1:0]        push_n;
    logic              pop_ok;

    assign push_n  = i_push_en ? i_push.count : 2'd0;
    assign pop_ok  = i_pop && (r_count != '0);
    assign n_head  = r_head + QPTR_W'(pop_ok);
    assign n_tail  = r_tail + QPTR_W'(push_n);
    assign n_count = r_count + QCNT_W'(push_n) - QCNT_W'(pop_ok);

    // Room is kept for the largest burst one item can cause.
    assign o_room  = (r_count <= QCNT_W'(QDEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_head];

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_tail] <= i_push.res0;
        end
        if (push_n == 2'd2) begin
            r_mem[r_tail + QPTR_W'(1)] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

endmodule

[rtl/core/midi_file_track_event_parser.sv]
// Standard MIDI file track chunk parser, one chunk byte per input item.
// Input channel (i_in_valid / o_in_ready) takes one raw byte of the track
// chunk per item, with a track start flag on the first byte and a chunk end
// flag on the last. Output channel (o_out_valid / i_out_ready) delivers one
// result item per cycle: a message byte with its event's delta, absolute tick,
// meta type, event boundary marks, done flag and error code.
// Each byte is decoded in the cycle it is accepted; its results (none, one or
// two) are written into a four-entry result queue that hands them out in
// order. A byte is taken every cycle while the queue holds at most two
// results, so one-result bytes stream at one per cycle; a running-status byte
// makes two results and the sustained rate is then set by the output port at
// one result per cycle. When the receiver stalls the queue fills and
// o_in_ready drops until two entries are free again.
// Reset clears the parser state and empties the queue; a byte with the track
// start flag clears the parser state the same way before it is decoded.
// After end of track, an error or the chunk end, bytes are taken and dropped
// until the next track start.
`timescale 1ns / 1ps

module midi_file_track_event_parser #(
    parameter int VLQ_MAX_BYTES = 4,
    parameter int TICK_BITS     = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_byte_value,
    input  logic              i_track_start,
    input  logic              i_chunk_end,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_msg_byte,
    output logic              o_has_data,
    output logic              o_first_of_event,
    output logic              o_last_of_event,
    output logic signed [8:0] o_meta_kind,
    output logic [27:0]       o_delta_ticks,
    output logic [31:0]       o_event_tick,
    output logic              o_track_done,
    output logic [1:0]        o_error_code,
    output logic              o_final_for_input
);
    import mftp_pkg::*;

    logic    accept;
    t_push   push;
    t_result head;

    assign accept = i_in_valid && o_in_ready;

    mftp_parser #(
        .VLQ_MAX_BYTES(VLQ_MAX_BYTES),
        .TICK_BITS    (TICK_BITS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte_value (i_byte_value),
        .i_track_start(i_track_start),
        .i_chunk_end  (i_chunk_end),
        .o_push       (push)
    );

    mftp_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_en(accept),
        .i_push   (push),
        .i_pop    (i_out_ready),
        .o_room   (o_in_ready),
        .o_valid  (o_out_valid),
        .o_head   (head)
    );

    assign o_msg_byte        = head.msg_byte;
    assign o_has_data        = head.has_data;
    assign o_first_of_event  = head.first_of_event;
    assign o_last_of_event   = head.last_of_event;
    assign o_meta_kind       = head.meta_kind;
    assign o_delta_ticks     = head.delta_ticks;
    assign o_event_tick      = head.event_tick;
    assign o_track_done      = head.track_done;
    assign o_error_code      = head.error_code;
    assign o_final_for_input = head.final_for_input;

    // A full queue always has something to hand out.
    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with an empty result queue");

    // Errors ride on the last result of their input item.
    a_error_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_error_code != ERR_NONE) |-> o_final_for_input)
        else $error("error code on a result that is not final for its item");

    // End of track closes its event and its input item.
    a_done_closes_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_track_done |-> o_last_of_event && o_final_for_input)
        else $error("track done on a result that does not close the event");

    // A result without data is either an empty event marker or an error report.
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_data && (o_error_code == ERR_NONE)
            |-> o_first_of_event && o_last_of_event)
        else $error("empty result that is neither a marker nor an error");

endmodule
